### hw/rtl/rbad_pkg.sv
// Package for the RGBA box-average downscaler.
// Holds payload structs, controller states, command/status structs and constants.
// No dependencies.
`default_nettype none

package rbad_pkg;

    localparam int MAX_TARGET     = 256;
    localparam int MAX_SOURCE_DIM = 8192;

    // Field and state widths.
    localparam int CH_W    = 8;
    localparam int DIM_W   = 14;
    localparam int POS_W   = 13;
    localparam int TGT_W   = 9;
    localparam int IDX_W   = 8;
    localparam int SUM_W   = 34;
    localparam int CNT_W   = 27;
    localparam int REM_W   = SUM_W + 1;
    localparam int CFG_IDX_W = 2;

    // Iteration counts of the two dividers.
    localparam int INIT_STEPS = DIM_W;
    localparam int DIV_STEPS  = CH_W;
    localparam int STEP_W     = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_H = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pix_t;

    typedef struct packed {
        logic [CH_W-1:0]  avg_red;
        logic [CH_W-1:0]  avg_green;
        logic [CH_W-1:0]  avg_blue;
        logic [CH_W-1:0]  avg_alpha;
        logic [IDX_W-1:0] col_index;
        logic [IDX_W-1:0] row_index;
        logic             frame_done;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_INIT,
        S_RST,
        S_ACC,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_load;
        logic init_step;
        logic restart;
        logic rd_en;
        logic acc;
        logic prep;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

### hw/rtl/rbad_ctrl.sv
// Controller state machine of the RGBA box-average downscaler.
// Sequences setup division, pixel accumulation, mean division and output.
// Depends on rbad_pkg.
`default_nettype none

module rbad_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic          pixel_valid,
    output logic               pixel_stall,
    input  wire rbad_pkg::sts_t sts,
    output rbad_pkg::cmd_t     cmd
);
    import rbad_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (pixel_valid) state_next = S_ACC;
            S_LOAD:  state_next = S_INIT;
            S_INIT:  if (step_reg == STEP_W'(INIT_STEPS - 1)) state_next = S_RST;
            S_RST:   state_next = S_IDLE;
            S_ACC:   state_next = sts.emit ? S_PREP : S_IDLE;
            S_PREP:  state_next = S_DIV;
            S_DIV:   if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = S_OUT;
            S_OUT:   if (!sts.out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (cfg_write)
        begin
            state_next = S_LOAD;
        end
    end

    // Step counter for the two iterative dividers.
    always_comb
    begin
        step_next = '0;
        if ((state_reg == S_INIT || state_reg == S_DIV) && !cfg_write)
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    // Outputs.
    always_comb
    begin
        cmd         = '0;
        pixel_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                pixel_stall = 1'b0;
                cmd.rd_en   = pixel_valid;
            end
            S_LOAD:  cmd.init_load = 1'b1;
            S_INIT:  cmd.init_step = 1'b1;
            S_RST:   cmd.restart   = 1'b1;
            S_ACC:   cmd.acc       = 1'b1;
            S_PREP:  cmd.prep      = 1'b1;
            S_DIV:   cmd.div_step  = 1'b1;
            S_OUT:   cmd.out_load  = !sts.out_busy;
            default: cmd = '0;
        endcase
        if (cfg_write)
        begin
            pixel_stall = 1'b1;
            cmd.rd_en   = 1'b0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rbad_dpath.sv
// Datapath of the RGBA box-average downscaler: configuration, band tracking,
// column sum memory, mean divider and output register. Depends on rbad_pkg.
`default_nettype none

module rbad_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [rbad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbad_pkg::DIM_W-1:0]    cfg_data,
    input  wire rbad_pkg::pix_t                pixel,
    output rbad_pkg::res_t                     result,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    input  wire rbad_pkg::cmd_t                cmd,
    output rbad_pkg::sts_t                     sts
);
    import rbad_pkg::*;

    localparam int MEM_W = 4 * SUM_W;

    // Configuration registers.
    logic [DIM_W-1:0] sw_reg, sh_reg;
    logic [TGT_W-1:0] tw_reg, th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= DIM_W'(1);
            sh_reg <= DIM_W'(1);
            tw_reg <= TGT_W'(1);
            th_reg <= TGT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SRC_W: sw_reg <= cfg_data;
                CFG_SRC_H: sh_reg <= cfg_data;
                CFG_TGT_W: tw_reg <= cfg_data[TGT_W-1:0];
                CFG_TGT_H: th_reg <= cfg_data[TGT_W-1:0];
                default:   sw_reg <= sw_reg;
            endcase
        end
    end

    // Effective sizes after clamping.
    function automatic logic [DIM_W-1:0] eff_src(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (v > DIM_W'(MAX_SOURCE_DIM))
            return DIM_W'(MAX_SOURCE_DIM);
        else
            return v;
    endfunction

    function automatic logic [TGT_W-1:0] eff_tgt(input logic [TGT_W-1:0] v,
                                                 input logic [DIM_W-1:0] src);
        logic [TGT_W-1:0] t;
        t = (v == '0) ? TGT_W'(1) : ((v > TGT_W'(MAX_TARGET)) ? TGT_W'(MAX_TARGET) : v);
        if (DIM_W'(t) > src)
            return src[TGT_W-1:0];
        else
            return t;
    endfunction

    logic [DIM_W-1:0] esw, esh;
    logic [TGT_W-1:0] etw, eth;

    assign esw = eff_src(sw_reg);
    assign esh = eff_src(sh_reg);
    assign etw = eff_tgt(tw_reg, esw);
    assign eth = eff_tgt(th_reg, esh);

    // Setup divider: source / target per axis, one quotient bit per cycle.
    logic [DIM_W-1:0] qw_reg, qh_reg, dsw_reg, dsh_reg;
    logic [TGT_W-1:0] rw_reg, rh_reg;
    logic [TGT_W:0]   trial_w, trial_h;
    logic             ge_w, ge_h;

    assign trial_w = {rw_reg, dsw_reg[DIM_W-1]};
    assign trial_h = {rh_reg, dsh_reg[DIM_W-1]};
    assign ge_w    = trial_w >= {1'b0, etw};
    assign ge_h    = trial_h >= {1'b0, eth};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg  <= DIM_W'(1);
            qh_reg  <= DIM_W'(1);
            rw_reg  <= '0;
            rh_reg  <= '0;
            dsw_reg <= '0;
            dsh_reg <= '0;
        end
        else if (cmd.init_load)
        begin
            qw_reg  <= '0;
            qh_reg  <= '0;
            rw_reg  <= '0;
            rh_reg  <= '0;
            dsw_reg <= esw;
            dsh_reg <= esh;
        end
        else if (cmd.init_step)
        begin
            qw_reg  <= {qw_reg[DIM_W-2:0], ge_w};
            qh_reg  <= {qh_reg[DIM_W-2:0], ge_h};
            rw_reg  <= ge_w ? TGT_W'(trial_w - {1'b0, etw}) : trial_w[TGT_W-1:0];
            rh_reg  <= ge_h ? TGT_W'(trial_h - {1'b0, eth}) : trial_h[TGT_W-1:0];
            dsw_reg <= {dsw_reg[DIM_W-2:0], 1'b0};
            dsh_reg <= {dsh_reg[DIM_W-2:0], 1'b0};
        end
    end

    // Position and band boundary registers.
    logic [POS_W-1:0] src_col_reg, src_row_reg;
    logic [TGT_W-1:0] band_col_reg, band_row_reg;
    logic [DIM_W-1:0] col_bnd_reg, row_bnd_reg, left_reg, top_reg;
    logic [TGT_W-1:0] col_frac_reg, row_frac_reg;

    // Next boundary, stepped incrementally by quotient and remainder.
    logic [TGT_W:0]   col_fsum, row_fsum;
    logic             col_wrap, row_wrap;
    logic [DIM_W-1:0] col_bnd_nx, row_bnd_nx;
    logic [TGT_W-1:0] col_frac_nx, row_frac_nx;

    assign col_fsum    = {1'b0, col_frac_reg} + {1'b0, rw_reg};
    assign row_fsum    = {1'b0, row_frac_reg} + {1'b0, rh_reg};
    assign col_wrap    = col_fsum >= {1'b0, etw};
    assign row_wrap    = row_fsum >= {1'b0, eth};
    assign col_frac_nx = col_wrap ? TGT_W'(col_fsum - {1'b0, etw}) : col_fsum[TGT_W-1:0];
    assign row_frac_nx = row_wrap ? TGT_W'(row_fsum - {1'b0, eth}) : row_fsum[TGT_W-1:0];
    assign col_bnd_nx  = col_bnd_reg + qw_reg + DIM_W'(col_wrap);
    assign row_bnd_nx  = row_bnd_reg + qh_reg + DIM_W'(row_wrap);

    logic col_close, row_close, row_end, frame_end;

    assign col_close = ({1'b0, src_col_reg} + DIM_W'(1)) >= col_bnd_reg;
    assign row_close = ({1'b0, src_row_reg} + DIM_W'(1)) >= row_bnd_reg;
    assign row_end   = ({1'b0, src_col_reg} + DIM_W'(1)) >= esw;
    assign frame_end = ({1'b0, src_row_reg} + DIM_W'(1)) >= esh;

    assign sts.emit = col_close && row_close;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            band_col_reg <= '0;
            band_row_reg <= '0;
            col_bnd_reg  <= DIM_W'(1);
            row_bnd_reg  <= DIM_W'(1);
            col_frac_reg <= '0;
            row_frac_reg <= '0;
            left_reg     <= '0;
            top_reg      <= '0;
        end
        else if (cmd.restart || (cmd.acc && row_end && frame_end))
        begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            band_col_reg <= '0;
            band_row_reg <= '0;
            col_bnd_reg  <= qw_reg;
            row_bnd_reg  <= qh_reg;
            col_frac_reg <= rw_reg;
            row_frac_reg <= rh_reg;
            left_reg     <= '0;
            top_reg      <= '0;
        end
        else if (cmd.acc)
        begin
            if (row_end)
            begin
                // Last column of the row: rewind to the first column band.
                src_col_reg  <= '0;
                band_col_reg <= '0;
                left_reg     <= '0;
                col_bnd_reg  <= qw_reg;
                col_frac_reg <= rw_reg;
                src_row_reg  <= src_row_reg + POS_W'(1);
                if (row_close)
                begin
                    band_row_reg <= band_row_reg + TGT_W'(1);
                    top_reg      <= row_bnd_reg;
                    row_bnd_reg  <= row_bnd_nx;
                    row_frac_reg <= row_frac_nx;
                end
            end
            else
            begin
                src_col_reg <= src_col_reg + POS_W'(1);
                if (col_close)
                begin
                    band_col_reg <= band_col_reg + TGT_W'(1);
                    left_reg     <= col_bnd_reg;
                    col_bnd_reg  <= col_bnd_nx;
                    col_frac_reg <= col_frac_nx;
                end
            end
        end
    end

    // Column sum memory with one valid bit per entry; an invalid entry reads zero.
    logic [MEM_W-1:0]      mem [MAX_TARGET];
    logic [MEM_W-1:0]      rdata_reg;
    logic [MAX_TARGET-1:0] valid_reg;
    logic [IDX_W-1:0]      col_addr;
    pix_t                  pix_reg;

    assign col_addr = band_col_reg[TGT_W-1] ? IDX_W'(MAX_TARGET - 1) : band_col_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[col_addr];
            pix_reg   <= pixel;
        end
    end

    logic [SUM_W-1:0] old_r, old_g, old_b, old_a;
    logic [SUM_W-1:0] new_r, new_g, new_b, new_a;

    assign old_r = valid_reg[col_addr] ? rdata_reg[4*SUM_W-1:3*SUM_W] : '0;
    assign old_g = valid_reg[col_addr] ? rdata_reg[3*SUM_W-1:2*SUM_W] : '0;
    assign old_b = valid_reg[col_addr] ? rdata_reg[2*SUM_W-1:SUM_W]   : '0;
    assign old_a = valid_reg[col_addr] ? rdata_reg[SUM_W-1:0]         : '0;
    assign new_r = old_r + SUM_W'(pix_reg.red);
    assign new_g = old_g + SUM_W'(pix_reg.green);
    assign new_b = old_b + SUM_W'(pix_reg.blue);
    assign new_a = old_a + SUM_W'(pix_reg.alpha);

    // A closing box writes zero back so the column starts the next band clean.
    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            mem[col_addr] <= sts.emit ? '0 : {new_r, new_g, new_b, new_a};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.restart || (cmd.acc && row_end && frame_end))
        begin
            valid_reg <= '0;
        end
        else if (cmd.acc)
        begin
            valid_reg[col_addr] <= 1'b1;
        end
    end

    // Box capture: sums, pixel count and coordinates of the closing box.
    logic [SUM_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg, sum_a_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] col_idx_reg, row_idx_reg;
    logic             done_reg;
    logic [DIM_W-1:0] box_h, box_w;
    logic [2*DIM_W-1:0] box_n;

    assign box_h = row_bnd_reg - top_reg;
    assign box_w = col_bnd_reg - left_reg;
    assign box_n = box_h * box_w;

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            sum_r_reg   <= new_r;
            sum_g_reg   <= new_g;
            sum_b_reg   <= new_b;
            sum_a_reg   <= new_a;
            cnt_reg     <= box_n[CNT_W-1:0];
            col_idx_reg <= band_col_reg[IDX_W-1:0];
            row_idx_reg <= band_row_reg[IDX_W-1:0];
            done_reg    <= ((band_col_reg + TGT_W'(1)) >= etw) &&
                           ((band_row_reg + TGT_W'(1)) >= eth);
        end
    end

    // Mean divider: (sum + count/2) / count, one quotient bit per cycle for
    // all four channels. The mean never exceeds eight bits.
    logic [REM_W-1:0] rem_r_reg, rem_g_reg, rem_b_reg, rem_a_reg;
    logic [SUM_W-1:0] dv_reg;
    logic [CH_W-1:0]  q_r_reg, q_g_reg, q_b_reg, q_a_reg;
    logic [REM_W-1:0] half, dvx;
    logic             ge_r, ge_g, ge_b, ge_a;

    assign half = REM_W'(cnt_reg[CNT_W-1:1]);
    assign dvx  = {1'b0, dv_reg};
    assign ge_r = rem_r_reg >= dvx;
    assign ge_g = rem_g_reg >= dvx;
    assign ge_b = rem_b_reg >= dvx;
    assign ge_a = rem_a_reg >= dvx;

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            rem_r_reg <= {1'b0, sum_r_reg} + half;
            rem_g_reg <= {1'b0, sum_g_reg} + half;
            rem_b_reg <= {1'b0, sum_b_reg} + half;
            rem_a_reg <= {1'b0, sum_a_reg} + half;
            dv_reg    <= {cnt_reg, {(SUM_W-CNT_W){1'b0}}};
            q_r_reg   <= '0;
            q_g_reg   <= '0;
            q_b_reg   <= '0;
            q_a_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (ge_r) rem_r_reg <= rem_r_reg - dvx;
            if (ge_g) rem_g_reg <= rem_g_reg - dvx;
            if (ge_b) rem_b_reg <= rem_b_reg - dvx;
            if (ge_a) rem_a_reg <= rem_a_reg - dvx;
            q_r_reg <= {q_r_reg[CH_W-2:0], ge_r};
            q_g_reg <= {q_g_reg[CH_W-2:0], ge_g};
            q_b_reg <= {q_b_reg[CH_W-2:0], ge_b};
            q_a_reg <= {q_a_reg[CH_W-2:0], ge_a};
            dv_reg  <= {1'b0, dv_reg[SUM_W-1:1]};
        end
    end

    // Output register: holds a word until the receiver takes it.
    res_t result_reg;
    logic result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.avg_red    <= q_r_reg;
            result_reg.avg_green  <= q_g_reg;
            result_reg.avg_blue   <= q_b_reg;
            result_reg.avg_alpha  <= q_a_reg;
            result_reg.col_index  <= col_idx_reg;
            result_reg.row_index  <= row_idx_reg;
            result_reg.frame_done <= done_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;
    assign sts.out_busy = result_valid_reg && result_stall;

endmodule

`default_nettype wire

### hw/rtl/rgba_box_average_downscaler.sv
// Top level of the RGBA box-average downscaler.
// Joins the controller (rbad_ctrl) and the datapath (rbad_dpath); uses rbad_pkg.
//
// Usage: source pixels enter in raster order on pixel/pixel_valid/pixel_stall;
// averaged target pixels leave on result/result_valid/result_stall, one word
// per box, with its target column, row and a flag on the last box of a frame.
// A word is taken at a clock edge where valid is high and stall is low.
// Sizes are written on cfg_write/cfg_index/cfg_data; every write restarts the
// frame and the block then stalls its input while it divides source by
// target size on both axes.
// Each pixel passes a sum memory read, then accumulate. A pixel that closes
// a box then goes through the mean divider, which yields one quotient bit
// per cycle, and the output step. A new pixel is taken only once the last
// one is through these steps.
// The output register lets the next pixels be accepted while a word waits;
// a stalled receiver holds the next closing pixel in the output step.
// After reset all sizes read 1 and a frame starts at once.
`default_nettype none

module rgba_box_average_downscaler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [rbad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbad_pkg::DIM_W-1:0]     cfg_data,
    input  wire rbad_pkg::pix_t                 pixel,
    input  wire logic                           pixel_valid,
    output logic                                pixel_stall,
    output rbad_pkg::res_t                      result,
    output logic                                result_valid,
    input  wire logic                           result_stall
);
    import rbad_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing.
    rbad_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Arithmetic and storage.
    rbad_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel        (pixel),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

### verif/rbad_checker.sv
// Checker for the RGBA box-average downscaler: watches the pixel, result and
// configuration ports, predicts each averaged word and compares it.
// Depends on rbad_pkg.
`timescale 1ns / 100ps

module rbad_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [rbad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbad_pkg::DIM_W-1:0]     cfg_data,
    input  rbad_pkg::pix_t                      pixel,
    input  wire logic                           pixel_valid,
    input  wire logic                           pixel_stall,
    input  rbad_pkg::res_t                      result,
    input  wire logic                           result_valid,
    input  wire logic                           result_stall,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  words_seen
);
    import rbad_pkg::*;

    // Shadow registers and frame position of the predictor.
    logic [DIM_W-1:0] src_w_reg, src_h_reg;
    logic [TGT_W-1:0] tgt_w_reg, tgt_h_reg;
    longint red_acc[MAX_TARGET], green_acc[MAX_TARGET];
    longint blue_acc[MAX_TARGET], alpha_acc[MAX_TARGET];
    int unsigned col_pos, row_pos, box_col, box_row, right_edge, bottom_edge, band_top;
    res_t expected_words[$];

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_w();
        return clamp_dim(src_w_reg, MAX_SOURCE_DIM);
    endfunction

    function automatic int unsigned eff_h();
        return clamp_dim(src_h_reg, MAX_SOURCE_DIM);
    endfunction

    function automatic int unsigned eff_tw();
        int unsigned t;
        t = clamp_dim(tgt_w_reg, MAX_TARGET);
        return (t > eff_w()) ? eff_w() : t;
    endfunction

    function automatic int unsigned eff_th();
        int unsigned t;
        t = clamp_dim(tgt_h_reg, MAX_TARGET);
        return (t > eff_h()) ? eff_h() : t;
    endfunction

    function automatic int unsigned box_edge(int unsigned i, int unsigned s, int unsigned t);
        longint unsigned p;
        p = longint'(i) * longint'(s);
        return int'(p / t);
    endfunction

    function automatic logic [CH_W-1:0] box_mean(longint s, longint n);
        return CH_W'((s + n / 2) / n);
    endfunction

    task automatic restart_frame();
        for (int i = 0; i < MAX_TARGET; i++)
        begin
            red_acc[i] = 0; green_acc[i] = 0; blue_acc[i] = 0; alpha_acc[i] = 0;
        end
        col_pos = 0; row_pos = 0; box_col = 0; box_row = 0; band_top = 0;
        right_edge = box_edge(1, eff_w(), eff_tw());
        bottom_edge = box_edge(1, eff_h(), eff_th());
    endtask

    // Advance the predictor by one source pixel.
    task automatic average_pixel(pix_t p);
        int unsigned sw, sh, tw, th, c, left;
        longint n;
        res_t w;
        sw = eff_w(); sh = eff_h(); tw = eff_tw(); th = eff_th();
        c = (box_col < MAX_TARGET) ? box_col : MAX_TARGET - 1;
        red_acc[c] += p.red; green_acc[c] += p.green;
        blue_acc[c] += p.blue; alpha_acc[c] += p.alpha;
        if (col_pos + 1 >= right_edge)
        begin
            if (row_pos + 1 >= bottom_edge)
            begin
                left = box_edge(box_col, sw, tw);
                n = longint'(bottom_edge - band_top) * longint'(right_edge - left);
                if (n == 0) n = 1;
                w.avg_red = box_mean(red_acc[c], n);
                w.avg_green = box_mean(green_acc[c], n);
                w.avg_blue = box_mean(blue_acc[c], n);
                w.avg_alpha = box_mean(alpha_acc[c], n);
                w.col_index = IDX_W'(box_col);
                w.row_index = IDX_W'(box_row);
                w.frame_done = (box_col + 1 >= tw) && (box_row + 1 >= th);
                expected_words.push_back(w);
                red_acc[c] = 0; green_acc[c] = 0; blue_acc[c] = 0; alpha_acc[c] = 0;
            end
            box_col++;
            right_edge = box_edge(box_col + 1, sw, tw);
        end
        col_pos++;
        if (col_pos >= sw)
        begin
            col_pos = 0;
            box_col = 0;
            right_edge = box_edge(1, sw, tw);
            row_pos++;
            if (row_pos >= sh)
                restart_frame();
            else if (row_pos >= bottom_edge)
            begin
                box_row++;
                band_top = bottom_edge;
                bottom_edge = box_edge(box_row + 1, sh, th);
            end
        end
    endtask

    // Compare one received word with the oldest prediction.
    task automatic check_word(res_t got);
        res_t w;
        if (expected_words.size() == 0)
        begin
            $error("unexpected result word %h", got);
            fail_count++;
            return;
        end
        w = expected_words.pop_front();
        if (got.avg_red !== w.avg_red)
            begin $error("avg_red exp %0d got %0d", w.avg_red, got.avg_red); fail_count++; end
        if (got.avg_green !== w.avg_green)
            begin $error("avg_green exp %0d got %0d", w.avg_green, got.avg_green); fail_count++; end
        if (got.avg_blue !== w.avg_blue)
            begin $error("avg_blue exp %0d got %0d", w.avg_blue, got.avg_blue); fail_count++; end
        if (got.avg_alpha !== w.avg_alpha)
            begin $error("avg_alpha exp %0d got %0d", w.avg_alpha, got.avg_alpha); fail_count++; end
        if (got.col_index !== w.col_index)
            begin $error("col_index exp %0d got %0d", w.col_index, got.col_index); fail_count++; end
        if (got.row_index !== w.row_index)
            begin $error("row_index exp %0d got %0d", w.row_index, got.row_index); fail_count++; end
        if (got.frame_done !== w.frame_done)
            begin $error("frame_done exp %0d got %0d", w.frame_done, got.frame_done); fail_count++; end
    endtask

    // Sample all ports at the rising edge; the stimulus changes them after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg = 1; src_h_reg = 1; tgt_w_reg = 1; tgt_h_reg = 1;
            restart_frame();
            expected_words.delete();
            fail_count = 0;
            words_seen = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_word(result);
                words_seen++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SRC_W: src_w_reg = cfg_data;
                    CFG_SRC_H: src_h_reg = cfg_data;
                    CFG_TGT_W: tgt_w_reg = TGT_W'(cfg_data);
                    CFG_TGT_H: tgt_h_reg = TGT_W'(cfg_data);
                    default: ;
                endcase
                restart_frame();
            end
            else if (pixel_valid && !pixel_stall)
                average_pixel(pixel);
        end
        pending = expected_words.size();
    end

endmodule

### verif/testbench.sv
// Top of the downscaler testbench: drives sizes and pixels with random gaps
// and stalls, and gives the verdict. Depends on rbad_pkg and rbad_checker.
`timescale 1ns / 100ps

module testbench;
    import rbad_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SRC_W;
    logic [DIM_W-1:0] cfg_data = '0;
    pix_t pixel = '0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    res_t result;
    logic result_valid;
    logic result_stall = 1'b0;
    int fail_count, pending, words_seen;
    int send_idle_pct = 0, stall_pct = 0;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;
    int pixels_sent = 0, frame_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rgba_box_average_downscaler i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pixel(pixel), .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
        .result(result), .result_valid(result_valid), .result_stall(result_stall)
    );

    rbad_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pixel(pixel), .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
        .result(result), .result_valid(result_valid), .result_stall(result_stall),
        .fail_count(fail_count), .pending(pending), .words_seen(words_seen)
    );

    // Receiver stall, random or held for a long stretch.
    always @(posedge clk)
        result_stall <= hold_off || ($urandom_range(99) < stall_pct);

    // Watchdog on cycles with no accepted word on either channel.
    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Write one register while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= DIM_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        repeat (20) @(posedge clk);
    endtask

    // End the pixel stream and wait until every predicted word has arrived.
    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
        drain();
        write_reg(CFG_SRC_W, sw);
        write_reg(CFG_SRC_H, sh);
        write_reg(CFG_TGT_W, tw);
        write_reg(CFG_TGT_H, th);
    endtask

    // Offer one pixel word and hold it until accepted; valid stays high
    // afterward so that the next word can follow without a gap.
    task automatic send_pixel(pix_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
        pixels_sent++;
    endtask

    function automatic pix_t random_pixel();
        pix_t p;
        p = pix_t'($urandom);
        // Bias toward the channel extremes now and then.
        if ($urandom_range(7) == 0) p = '1;
        else if ($urandom_range(7) == 0) p = '0;
        return p;
    endfunction

    task automatic send_frame(int unsigned npix);
        for (int i = 0; i < npix; i++)
            send_pixel(random_pixel());
        frame_count++;
    endtask

    initial
    begin
        int unsigned sw, sh, tw, th;
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (20) @(posedge clk);

        // Reset sizes 1x1: every pixel is a box of its own.
        send_pixel('1);
        send_pixel('0);
        // Rounding: 2x1 into 1x1 with odd sums, then upscale clamp 3x2 -> 9x9.
        set_sizes(2, 1, 1, 1);
        send_pixel(32'h01_FF_00_80);
        send_pixel(32'h00_FE_01_7F);
        set_sizes(3, 2, 9, 9);
        send_frame(6);
        // Uneven boundaries, a register write mid-frame, and size zero as one.
        set_sizes(5, 3, 2, 2);
        send_frame(4);
        set_sizes(0, 0, 0, 0);
        send_pixel(32'hA5_5A_C3_3C);
        // Largest target with a narrow band.
        set_sizes(300, 1, 256, 1);
        send_frame(300);
        drain();

        // Random phases of gap and stall levels over small frames.
        phase = 0;
        while (pixels_sent < 580)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 75; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 75; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            sw = $urandom_range(12, 1);
            sh = $urandom_range(8, 1);
            tw = $urandom_range(14, 0);
            th = $urandom_range(10, 0);
            if ($urandom_range(9) == 0) sw = 8192 + $urandom_range(8191);
            set_sizes(sw, (sw > 64) ? 1 : sh, tw, th);
            send_frame((sw > 64) ? 40 : sw * ((sw > 64) ? 1 : sh) * 2);
            phase++;
        end

        // Long receiver hold-off so the block backs up its input.
        drain();
        send_idle_pct = 0; stall_pct = 0;
        set_sizes(4, 4, 4, 4);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            send_frame(32);
        join
        drain();

        $display("Sent %0d pixels over %0d frames; checked %0d averaged words.",
            pixels_sent, frame_count, words_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### rgba_box_average_downscaler.f
hw/rtl/rbad_pkg.sv
hw/rtl/rbad_ctrl.sv
hw/rtl/rbad_dpath.sv
hw/rtl/rgba_box_average_downscaler.sv
verif/rbad_checker.sv
verif/testbench.sv
